[rtl/pcc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the pearson correlation unit
// no dependencies

package pcc_pkg;

    // accumulator widths
    localparam int CountW = 17;
    localparam int SumW   = 33;
    localparam int SqW    = 47;
    localparam int CrossW = 48;

    // serial multiplier widths
    localparam int MulAW  = 160;
    localparam int MulBW  = 64;
    localparam int DevW   = 64;
    localparam int DenW   = 128;
    localparam int NumW   = 67;

    // correlation magnitude search
    localparam int CorrW  = 16;
    localparam logic [CorrW-1:0] CorrOne = 16'h8000;
    localparam logic [CorrW-1:0] CorrMax = 16'h7fff;

    typedef struct packed {
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
        logic               last_sample;
    } pcc_in_t;

    typedef struct packed {
        logic signed [15:0] correlation;
        logic               defined;
    } pcc_out_t;

    // multiplier operations, issued in this order
    typedef enum logic [3:0] {
        OP_NSXX  = 4'd0,
        OP_SXSQ  = 4'd1,
        OP_NSYY  = 4'd2,
        OP_SYSQ  = 4'd3,
        OP_NSXY  = 4'd4,
        OP_SXSY  = 4'd5,
        OP_DEN   = 4'd6,
        OP_NUMSQ = 4'd7,
        OP_LHS   = 4'd8
    } pcc_op_t;

    typedef struct packed {
        logic    accept;
        logic    start;
        logic    finish;
        logic    init;
        logic    step;
        logic    emit;
        pcc_op_t op;
    } pcc_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic den_zero;
        logic search_done;
        logic out_busy;
    } pcc_sts_t;

endpackage

[rtl/pearson_correlation_unit.sv]
`timescale 1ns / 1ps
// top level of the streaming pearson correlation unit
// depends on pcc_pkg, pcc_ctrl, pcc_datapath

// Pairs are accumulated one per cycle. A pair marked last closes the column:
// the unit then computes the two deviations, the numerator, the denominator
// product and the Q1.15 magnitude on one shift-add multiplier that retires one
// multiplier bit per cycle, followed by a 15 to 16 step binary search that
// reuses it. No new pair is taken while a column end is computed; a column
// whose denominator is zero finishes after the deviations. Results wait in an
// output register, so a pending result does not hold up accumulation of the
// next column.
module pearson_correlation_unit #(
    parameter int MAX_COUNT   = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pcc_pkg::pcc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pcc_pkg::pcc_out_t out_data
);
    import pcc_pkg::*;

    pcc_cmd_t cmd;
    pcc_sts_t sts;

    // sequencer
    pcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.last_sample),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic
    pcc_datapath #(
        .MAX_COUNT   (MAX_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[rtl/pcc_ctrl.sv]
`timescale 1ns / 1ps
// controller: sequences accumulation, the serial multiplies and the search
// depends on pcc_pkg

module pcc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  pcc_pkg::pcc_sts_t sts,
    output pcc_pkg::pcc_cmd_t cmd
);
    import pcc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_CHECK = 6'b001000,
        ST_STEP  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t  state_reg, state_next;
    pcc_op_t op_reg, op_next;

    // state and current operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_NSXX;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && in_last)
                begin
                    op_next    = OP_NSXX;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.finish = 1'b1;
                    case (op_reg)
                        OP_SYSQ:  state_next = ST_CHECK;
                        OP_NUMSQ: state_next = ST_STEP;
                        OP_LHS:   state_next = ST_STEP;
                        OP_NSXX:
                        begin
                            op_next    = OP_SXSQ;
                            state_next = ST_START;
                        end
                        OP_SXSQ:
                        begin
                            op_next    = OP_NSYY;
                            state_next = ST_START;
                        end
                        OP_NSYY:
                        begin
                            op_next    = OP_SYSQ;
                            state_next = ST_START;
                        end
                        OP_NSXY:
                        begin
                            op_next    = OP_SXSY;
                            state_next = ST_START;
                        end
                        OP_SXSY:
                        begin
                            op_next    = OP_DEN;
                            state_next = ST_START;
                        end
                        OP_DEN:
                        begin
                            op_next    = OP_NUMSQ;
                            state_next = ST_START;
                        end
                        default: state_next = ST_EMIT;
                    endcase
                end
            end
            ST_CHECK:
            begin
                cmd.init = 1'b1;
                if (sts.den_zero)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    op_next    = OP_NSXY;
                    state_next = ST_START;
                end
            end
            ST_STEP:
            begin
                if (sts.search_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    op_next    = OP_LHS;
                    state_next = ST_START;
                end
            end
            ST_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[rtl/pcc_datapath.sv]
`timescale 1ns / 1ps
// datapath: accumulators, shift-add multiplier, magnitude search, output register
// depends on pcc_pkg

module pcc_datapath #(
    parameter int MAX_COUNT   = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pcc_pkg::pcc_in_t  in_data,
    input  pcc_pkg::pcc_cmd_t cmd,
    output pcc_pkg::pcc_sts_t sts,
    output logic              out_valid,
    input  logic              out_ready,
    output pcc_pkg::pcc_out_t out_data
);
    import pcc_pkg::*;

    localparam int Shift = 16 - SAMPLE_BITS;

    logic [CountW-1:0]        count_reg;
    logic signed [SumW-1:0]   sx_reg, sy_reg;
    logic [SqW-1:0]           sxx_reg, syy_reg;
    logic signed [CrossW-1:0] sxy_reg;
    logic [MulAW-1:0]         a_reg, acc_reg;
    logic [MulBW-1:0]         b_reg;
    logic [DevW-1:0]          dx_reg, dy_reg;
    logic signed [NumW-1:0]   num_reg;
    logic [DenW-1:0]          d_reg, r_reg;
    logic [CorrW-1:0]         lo_reg, hi_reg, mid_reg;
    logic [31:0]              kk_reg;
    logic                     out_valid_reg;
    pcc_out_t                 out_reg;

    logic signed [15:0]       x_sh, y_sh, x_v, y_v;
    logic signed [31:0]       xx, yy, xy;
    logic [SumW-1:0]          ax, ay;
    logic [CrossW-1:0]        axy;
    logic [NumW-1:0]          anum;
    logic [DevW-1:0]          mag;
    logic [MulAW-1:0]         a_sel;
    logic [MulBW-1:0]         b_sel;
    logic [MulAW-1:0]         prod_signed;
    logic                     prod_neg;
    logic [CorrW:0]           mid_sum;
    logic [CorrW:0]           k_wide;
    logic [CorrW-1:0]         k_val;
    logic signed [15:0]       corr_val;

    // sample sign extension from SAMPLE_BITS
    assign x_sh = in_data.x_sample <<< Shift;
    assign y_sh = in_data.y_sample <<< Shift;
    assign x_v  = x_sh >>> Shift;
    assign y_v  = y_sh >>> Shift;
    assign xx   = x_v * x_v;
    assign yy   = y_v * y_v;
    assign xy   = x_v * y_v;

    // magnitudes of the signed sums and of the numerator
    assign ax   = sx_reg[SumW-1] ? SumW'(-sx_reg) : SumW'(sx_reg);
    assign ay   = sy_reg[SumW-1] ? SumW'(-sy_reg) : SumW'(sy_reg);
    assign axy  = sxy_reg[CrossW-1] ? CrossW'(-sxy_reg) : CrossW'(sxy_reg);
    assign anum = num_reg[NumW-1] ? NumW'(-num_reg) : NumW'(num_reg);
    assign mag  = anum[DevW-1:0];

    // multiplier operand select
    always_comb
    begin
        a_sel    = '0;
        b_sel    = '0;
        prod_neg = 1'b0;
        case (cmd.op)
            OP_NSXX:
            begin
                a_sel = MulAW'(sxx_reg);
                b_sel = MulBW'(count_reg);
            end
            OP_SXSQ:
            begin
                a_sel = MulAW'(ax);
                b_sel = MulBW'(ax);
            end
            OP_NSYY:
            begin
                a_sel = MulAW'(syy_reg);
                b_sel = MulBW'(count_reg);
            end
            OP_SYSQ:
            begin
                a_sel = MulAW'(ay);
                b_sel = MulBW'(ay);
            end
            OP_NSXY:
            begin
                a_sel    = MulAW'(axy);
                b_sel    = MulBW'(count_reg);
                prod_neg = sxy_reg[CrossW-1];
            end
            OP_SXSY:
            begin
                a_sel    = MulAW'(ax);
                b_sel    = MulBW'(ay);
                prod_neg = sx_reg[SumW-1] ^ sy_reg[SumW-1];
            end
            OP_DEN:
            begin
                a_sel = MulAW'(dx_reg);
                b_sel = dy_reg;
            end
            OP_NUMSQ:
            begin
                a_sel = MulAW'(mag);
                b_sel = mag;
            end
            OP_LHS:
            begin
                a_sel = MulAW'(d_reg);
                b_sel = MulBW'(kk_reg);
            end
            default:
            begin
                a_sel = '0;
                b_sel = '0;
            end
        endcase
    end

    // signed product for the numerator terms
    assign prod_signed = prod_neg ? -acc_reg : acc_reg;

    // search midpoint of the current bounds and its odd edge, twice the midpoint less one
    assign mid_sum  = ({1'b0, lo_reg} + {1'b0, hi_reg} + 1'b1) >> 1;
    assign k_wide   = {mid_sum[CorrW-1:0], 1'b0} - 1'b1;
    assign k_val    = k_wide[CorrW-1:0];

    // result sign and saturation
    always_comb
    begin
        if (num_reg[NumW-1])
            corr_val = -$signed(lo_reg);
        else if (lo_reg == CorrOne)
            corr_val = $signed(CorrMax);
        else
            corr_val = $signed(lo_reg);
    end

    // accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
        end
        else if (cmd.emit)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
        end
        else if (cmd.accept && (32'(count_reg) < MAX_COUNT))
        begin
            count_reg <= count_reg + 1'b1;
            sx_reg    <= sx_reg + SumW'(x_v);
            sy_reg    <= sy_reg + SumW'(y_v);
            sxx_reg   <= sxx_reg + SqW'(unsigned'(xx));
            syy_reg   <= syy_reg + SqW'(unsigned'(yy));
            sxy_reg   <= sxy_reg + CrossW'(xy);
        end
    end

    // shift-add multiplier, one multiplier bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg   <= a_sel;
            b_reg   <= b_sel;
            acc_reg <= '0;
        end
        else if (b_reg != '0)
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + a_reg;
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    // store results of each operation but OP_LHS, and the squared odd edge on a step
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            case (cmd.op)
                OP_NSXX:  dx_reg  <= acc_reg[DevW-1:0];
                OP_SXSQ:  dx_reg  <= dx_reg - acc_reg[DevW-1:0];
                OP_NSYY:  dy_reg  <= acc_reg[DevW-1:0];
                OP_SYSQ:  dy_reg  <= dy_reg - acc_reg[DevW-1:0];
                OP_NSXY:  num_reg <= $signed(prod_signed[NumW-1:0]);
                OP_SXSY:  num_reg <= num_reg - $signed(prod_signed[NumW-1:0]);
                OP_DEN:   d_reg   <= acc_reg[DenW-1:0];
                OP_NUMSQ: r_reg   <= acc_reg[DenW-1:0];
                default:  ;
            endcase
        end
        if (cmd.step)
            kk_reg <= 32'(k_val) * 32'(k_val);
    end

    // binary search bounds; the midpoint is held while the square of its odd edge is tested
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            lo_reg <= '0;
            hi_reg <= CorrOne;
        end
        else if (cmd.finish && (cmd.op == OP_LHS))
        begin
            if (acc_reg <= {r_reg, 32'd0})
                lo_reg <= mid_reg;
            else
                hi_reg <= mid_reg - 1'b1;
        end
        if (cmd.step)
            mid_reg <= mid_sum[CorrW-1:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.defined     <= ~sts.den_zero;
            out_reg.correlation <= sts.den_zero ? 16'sd0 : corr_val;
        end
    end

    assign sts.mul_done    = (b_reg == '0);
    assign sts.den_zero    = (dx_reg == '0) || (dy_reg == '0);
    assign sts.search_done = (lo_reg == hi_reg);
    assign sts.out_busy    = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

endmodule

[rtl/pcc_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the pearson correlation unit, bound to the top level
// depends on pcc_pkg

module pcc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input pcc_pkg::pcc_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input pcc_pkg::pcc_out_t out_data
);
    import pcc_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result beat changed while stalled");

    // intake stops after a closing pair is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.last_sample) |=> !in_ready)
    else $error("input taken right after a last pair");

    // no result appears the cycle after a closing pair
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.last_sample) |=> !$rose(out_valid))
    else $error("result appeared too early");

    // undefined results read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.defined) |-> (out_data.correlation == 16'sd0))
    else $error("undefined result not zero");

endmodule

bind pearson_correlation_unit pcc_checker u_pcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[sim/pearson_correlation_unit_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for pearson_correlation_unit: directed columns, then random
// columns, checked against typed-in values or an exact integer model of the correlation
// depends on pcc_pkg and the pearson_correlation_unit rtl

module pearson_correlation_unit_tb;
    import pcc_pkg::*;

    localparam int MaxPairs   = 65536;
    localparam int StallLimit = 20000;
    localparam int RandPairs  = 1730;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    pcc_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    pcc_out_t out_data;

    pearson_correlation_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // running column sums of the model
    int unsigned     col_pairs;
    longint          col_sx;
    longint          col_sy;
    longint unsigned col_sxx;
    longint unsigned col_syy;
    longint          col_sxy;

    pcc_out_t coeff_queue[$];
    int       mismatches;
    int       results_seen;
    int       columns_sent;
    int       pairs_sent;
    int       undefined_seen;
    int       idle_cycles;
    bit       steady;

    // directed columns; expected value typed in where it is obvious
    typedef struct {
        int x;
        int y;
        bit last;
        bit typed;
        int corr;
        bit defd;
    } row_t;

    row_t rows[] = '{
        // one-pair column has no spread
        '{5, 7, 1, 1, 0, 0},
        // constant x column
        '{3, 1, 0, 0, 0, 0}, '{3, 2, 1, 1, 0, 0},
        // extremes, perfect positive correlation saturates
        '{-32768, -32768, 0, 0, 0, 0}, '{32767, 32767, 1, 1, 32767, 1},
        // perfect negative correlation keeps -1
        '{-32768, 32767, 0, 0, 0, 0}, '{32767, -32768, 1, 1, -32768, 1},
        '{0, 0, 0, 0, 0, 0}, '{1, 1, 0, 0, 0, 0}, '{2, 2, 1, 1, 32767, 1},
        // constant y column
        '{1, 0, 0, 0, 0, 0}, '{2, 0, 1, 1, 0, 0},
        // general cases, model only
        '{1, 3, 0, 0, 0, 0}, '{2, 1, 0, 0, 0, 0}, '{3, 2, 1, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0}, '{-1, -1, 0, 0, 0, 0}, '{32767, -32768, 0, 0, 0, 0},
        '{-32768, 0, 1, 0, 0, 0},
        '{-5, 9, 0, 0, 0, 0}, '{100, -3, 0, 0, 0, 0}, '{-32768, 32767, 1, 0, 0, 0}
    };

    function automatic void clear_column();
        col_pairs = 0;
        col_sx    = 0;
        col_sy    = 0;
        col_sxx   = 0;
        col_syy   = 0;
        col_sxy   = 0;
    endfunction

    // add one pair; on a last pair produce the q1.15 coefficient
    function automatic bit correlate_pair(pcc_in_t p, output pcc_out_t coeff);
        longint          x;
        longint          y;
        logic [127:0]    dev_x;
        logic [127:0]    dev_y;
        logic signed [127:0] num;
        logic [127:0]    mag;
        logic [255:0]    den;
        logic [255:0]    rhs;
        logic [255:0]    lhs;
        logic [63:0]     k;
        int              lo;
        int              hi;
        int              mid;
        int              c;
        x = p.x_sample;
        y = p.y_sample;
        coeff = '0;
        if (col_pairs < MaxPairs)
        begin
            col_sx    += x;
            col_sy    += y;
            col_sxx   += longint'(x * x);
            col_syy   += longint'(y * y);
            col_sxy   += x * y;
            col_pairs++;
        end
        if (!p.last_sample)
            return 0;
        dev_x = 128'(col_pairs) * 128'(col_sxx) - 128'(col_sx * col_sx);
        dev_y = 128'(col_pairs) * 128'(col_syy) - 128'(col_sy * col_sy);
        if (dev_x == 0 || dev_y == 0)
        begin
            clear_column();
            return 1;
        end
        num = 128'(longint'(col_pairs)) * 128'(col_sxy) - 128'(col_sx) * 128'(col_sy);
        mag = num < 0 ? -num : num;
        den = 256'(dev_x) * 256'(dev_y);
        rhs = (256'(mag) * 256'(mag)) << 32;
        // largest magnitude whose lower rounding edge does not exceed |r|
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            k   = 2 * mid - 1;
            lhs = 256'(k * k) * den;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        c = num < 0 ? -lo : (lo > 32767 ? 32767 : lo);
        coeff.correlation = 16'(c);
        coeff.defined     = 1'b1;
        clear_column();
        return 1;
    endfunction

    // drive one beat and record what it should produce
    task automatic send_pair(int x, int y, bit last, bit typed = 0, int corr = 0,
                             bit defd = 0);
        pcc_in_t  p;
        pcc_out_t coeff;
        p.x_sample    = 16'(x);
        p.y_sample    = 16'(y);
        p.last_sample = last;
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (!in_ready);
        pairs_sent++;
        if (correlate_pair(p, coeff))
        begin
            columns_sent++;
            if (typed)
            begin
                coeff.correlation = 16'(corr);
                coeff.defined     = defd;
            end
            coeff_queue.push_back(coeff);
        end
        // idle cycles unless steady, each taken with a chance of 28 in a hundred
        while (!steady && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        while (coeff_queue.size() != 0)
            @(posedge clk);
    endtask

    // random sample, biased toward the extremes and small values
    function automatic int pick_sample();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(0, 15) - 8;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int clip16(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stalls, compare against the oldest expectation
    initial
    begin
        pcc_out_t want;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (coeff_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result corr=%0d defined=%0b",
                                 out_data.correlation, out_data.defined);
                end
                else
                begin
                    want = coeff_queue.pop_front();
                    if (!want.defined)
                        undefined_seen++;
                    if (out_data.correlation !== want.correlation ||
                        out_data.defined !== want.defined)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected corr=%0d defined=%0b, got corr=%0d defined=%0b",
                                     results_seen, want.correlation, want.defined,
                                     out_data.correlation, out_data.defined);
                    end
                end
            end
            out_ready <= steady || ($urandom_range(99) >= 28);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= StallLimit)
        begin
            $display("pearson_correlation_unit_tb NOT OK");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int len;
        int mode;
        int x;
        int y;
        int sent;
        int gain;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        steady   = 1'b0;
        clear_column();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed columns
        foreach (rows[i])
            send_pair(rows[i].x, rows[i].y, rows[i].last, rows[i].typed,
                      rows[i].corr, rows[i].defd);
        in_valid <= 1'b0;
        drain_results();

        // random columns, first stretch without any idling
        sent = 0;
        while (sent < RandPairs)
        begin
            steady = sent < 300;
            case ($urandom_range(19))
                0:       len = $urandom_range(100, 300);
                1, 2, 3: len = $urandom_range(13, 60);
                default: len = $urandom_range(1, 12);
            endcase
            mode = $urandom_range(4);
            gain = $urandom_range(0, 1) ? 1 : -1;
            for (int j = 0; j < len; j++)
            begin
                x = mode == 3 ? 1234 : pick_sample();
                case (mode)
                    1: y = clip16(gain * x + int'($urandom_range(0, 64)) - 32);
                    2: y = clip16(gain * (x / 4) + pick_sample() / 2);
                    4: y = (j % 2) ? 32767 : -32768;
                    default: y = pick_sample();
                endcase
                send_pair(x, y, j == len - 1);
            end
            sent += len;
            // sender holds off once until everything has come back
            if (sent > 900 && sent - len <= 900)
            begin
                in_valid <= 1'b0;
                drain_results();
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        drain_results();
        repeat (1200) @(posedge clk);
        $display("covered %0d pairs in %0d columns, %0d results (%0d undefined)",
                 pairs_sent, columns_sent, results_seen, undefined_seen);
        $display("including extremes, constant and one-pair columns and stalls on both sides");
        if (mismatches == 0 && coeff_queue.size() == 0)
            $display("pearson_correlation_unit_tb OK");
        else
            $display("pearson_correlation_unit_tb NOT OK");
        $finish;
    end

endmodule

[pearson_correlation_unit.f]
rtl/pcc_pkg.sv
rtl/pcc_ctrl.sv
rtl/pcc_datapath.sv
rtl/pearson_correlation_unit.sv
rtl/pcc_checker.sv
sim/pearson_correlation_unit_tb.sv
